### design/hct_pkg.sv
// ----------------------------------------------------------------------------
// hct_pkg: shared definitions for the horspool comparison tracer
// widths, register indexes, parameter defaults and the sequencer states
// ----------------------------------------------------------------------------
package hct_pkg;

    // parameter defaults
    localparam int MAX_PATTERN_DEF    = 16;
    localparam int POSITION_WIDTH_DEF = 32;

    // fixed field widths
    localparam int TEXT_BYTE_W       = 8;
    localparam int COMPARED_POS_W    = 32;
    localparam int LENGTH_REG_W      = 5;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 64;
    localparam int PATTERN_REG_BYTES = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PATTERN_HIGH   = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SHIFT
    } t_state;

endpackage

### design/hct_text_if.sv
// ----------------------------------------------------------------------------
// hct_text_if: text byte channel
// valid/ready handshake carrying one text byte and its end-of-text flag
// ----------------------------------------------------------------------------
interface hct_text_if;
    logic                               valid;
    logic                               ready;
    logic [hct_pkg::TEXT_BYTE_W-1:0]    text_byte;
    logic                               end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

### design/hct_result_if.sv
// ----------------------------------------------------------------------------
// hct_result_if: comparison result channel
// valid/ready handshake carrying one compared position and its run flags
// ----------------------------------------------------------------------------
interface hct_result_if;
    logic                                valid;
    logic                                ready;
    logic [hct_pkg::COMPARED_POS_W-1:0]  compared_position;
    logic                                window_matched;
    logic                                last_of_run;

    modport source (output valid, output compared_position, output window_matched,
                    output last_of_run, input ready);
    modport sink   (input valid, input compared_position, input window_matched,
                    input last_of_run, output ready);
endinterface

### design/hct_cfg_if.sv
// ----------------------------------------------------------------------------
// hct_cfg_if: configuration write channel
// valid/ready handshake carrying a register index and write data
// ----------------------------------------------------------------------------
interface hct_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hct_pkg::CFG_INDEX_W-1:0]   reg_index;
    logic [hct_pkg::CFG_DATA_W-1:0]    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### design/hct_ram.sv
// ----------------------------------------------------------------------------
// hct_ram: generic single-write, single-read synchronous ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module hct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/horspool_comparison_tracer_top.sv
// ----------------------------------------------------------------------------
// horspool_comparison_tracer_top: horspool style comparison tracer
// streams text bytes against a configured pattern and reports each compare
// ----------------------------------------------------------------------------
// Text bytes arrive one per transaction on i_text. Every byte, unless the
// position counter has saturated, is stored in a small ring ram that holds
// the last MAX_PATTERN bytes. When a byte completes the current window, the
// window is compared with the pattern from right to left, one byte per cycle
// while the output is not stalled, and every compare produces one
// transaction on o_result with its 1-based text position; the run ends at
// the first mismatch or at a full match. The compared bytes are read by the
// single ram read port walking the window. Then the pattern is scanned for
// the last-occurrence shift, one pattern byte per cycle; after a full match
// the scan is skipped. Output stalls hold the compare run. No clearing pass
// is needed after reset: the ring is only read within the current text.
// Configuration may be written only while the block is idle.
// ----------------------------------------------------------------------------
module horspool_comparison_tracer_top #(
    parameter int MAX_PATTERN    = hct_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_WIDTH = hct_pkg::POSITION_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hct_text_if.sink      i_text,
    hct_result_if.source  o_result,
    hct_cfg_if.sink       i_cfg
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PW    = POSITION_WIDTH;
    localparam logic [PW-1:0]    POS_MAX   = {PW{1'b1}};
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_PATTERN - 1);
    localparam int PAT_W = 8 * hct_pkg::PATTERN_REG_BYTES;

    // effective pattern length: zero reads as one, clipped to the ring depth
    function automatic logic [LEN_W-1:0] eff_len(input logic [hct_pkg::LENGTH_REG_W-1:0] n);
        logic [LEN_W-1:0] l;
        if (n == '0) begin
            l = LEN_W'(1);
        end else if (n > MAX_PATTERN) begin
            l = LEN_W'(MAX_PATTERN);
        end else begin
            l = LEN_W'(n);
        end
        return l;
    endfunction

    // pattern byte i, bytes past the register file read as zero
    function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pv,
                                            input logic [IDX_W-1:0] i);
        logic [IDX_W+3:0] ie;
        logic [7:0]       b;
        ie = {4'b0000, i};
        if (ie < (IDX_W + 4)'(hct_pkg::PATTERN_REG_BYTES)) begin
            b = pv[{ie[3:0], 3'b000} +: 8];
        end else begin
            b = 8'h00;
        end
        return b;
    endfunction

    function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : IDX_W'(s + IDX_W'(1));
    endfunction

    function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] s);
        return (s == '0) ? LAST_SLOT : IDX_W'(s - IDX_W'(1));
    endfunction

    // configuration registers
    logic [hct_pkg::LENGTH_REG_W-1:0] r_pattern_length, n_pattern_length;
    logic [hct_pkg::CFG_DATA_W-1:0]   r_pattern_low, n_pattern_low;
    logic [hct_pkg::CFG_DATA_W-1:0]   r_pattern_high, n_pattern_high;

    // sequencer and text state
    hct_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_count, n_count;       // bytes taken in this text
    logic [PW-1:0]    r_wend, n_wend;         // position of the window's last byte
    logic [IDX_W-1:0] r_wr_slot, n_wr_slot;   // ring slot for the next byte

    // compare run state
    logic [PW-1:0]    r_pos, n_pos;           // position under compare
    logic [IDX_W-1:0] r_slot, n_slot;         // its ring slot
    logic [IDX_W-1:0] r_idx, n_idx;           // its pattern index
    logic [7:0]       r_first, n_first;       // newest byte, forwarded around the ram
    logic             r_eot, n_eot;

    // shift scan state
    logic [7:0]       r_sym, n_sym;
    logic [IDX_W-1:0] r_scan, n_scan;
    logic [LEN_W-1:0] r_shift, n_shift;

    // output register
    logic                                r_out_valid, n_out_valid;
    logic [hct_pkg::COMPARED_POS_W-1:0]  r_out_pos, n_out_pos;
    logic                                r_out_full, n_out_full;
    logic                                r_out_last, n_out_last;

    // ram ports
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [7:0]       ram_rd_data;

    logic [PAT_W-1:0] pv;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] len_m1;
    logic             in_fire, cfg_fire, stored, start_cmp;
    logic [7:0]       text_cur, cmp_pat;
    logic             eq, res_last, res_full, slot_free, emit;
    logic             scan_done, shift_hit;
    logic [PW:0]      shift_sum;
    logic [PW-1:0]    wend_sat;

    assign pv     = {r_pattern_high, r_pattern_low};
    assign len    = eff_len(r_pattern_length);
    assign len_m1 = IDX_W'(len - LEN_W'(1));

    // intake only between runs
    assign i_text.ready = (r_state == hct_pkg::ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign in_fire      = i_text.valid && i_text.ready;
    assign cfg_fire     = i_cfg.valid && i_cfg.ready;

    // a byte is stored unless the position counter has saturated
    assign stored    = (r_count != POS_MAX);
    // window complete and not reaching before the start of the text
    assign start_cmp = stored && (r_count == r_wend) && !(r_count < PW'(len_m1));

    // current compare: the rightmost byte comes from the intake register
    assign text_cur  = (r_idx == len_m1) ? r_first : ram_rd_data;
    assign cmp_pat   = pat_byte(pv, r_idx);
    assign eq        = (text_cur == cmp_pat);
    assign res_full  = eq && (r_idx == '0);
    assign res_last  = !eq || (r_idx == '0);
    assign slot_free = !r_out_valid || o_result.ready;
    assign emit      = (r_state == hct_pkg::ST_CMP) && slot_free;

    // shift scan over pattern bytes 0 to len-2
    assign scan_done = ((int'(r_scan) + 1) >= int'(len));
    assign shift_hit = (pat_byte(pv, r_scan) == r_sym);
    assign shift_sum = {1'b0, r_wend} + (PW + 1)'(r_shift);
    assign wend_sat  = shift_sum[PW] ? POS_MAX : shift_sum[PW-1:0];

    // keep the read address on the current slot while stalled so the data holds
    assign ram_wr_en   = in_fire && stored;
    assign ram_rd_addr = (emit && !res_last) ? slot_prev(r_slot) : r_slot;

    hct_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wr_slot),
        .i_wr_data (i_text.text_byte),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hct_pkg::ST_IDLE: begin
                if (in_fire && start_cmp) begin
                    n_state = hct_pkg::ST_CMP;
                end
            end
            hct_pkg::ST_CMP: begin
                if (emit && res_last) begin
                    n_state = hct_pkg::ST_SHIFT;
                end
            end
            hct_pkg::ST_SHIFT: begin
                if (scan_done) begin
                    n_state = hct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hct_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_pattern_length = r_pattern_length;
        n_pattern_low    = r_pattern_low;
        n_pattern_high   = r_pattern_high;
        n_count          = r_count;
        n_wend           = r_wend;
        n_wr_slot        = r_wr_slot;
        n_pos            = r_pos;
        n_slot           = r_slot;
        n_idx            = r_idx;
        n_first          = r_first;
        n_eot            = r_eot;
        n_sym            = r_sym;
        n_scan           = r_scan;
        n_shift          = r_shift;
        n_out_valid      = r_out_valid;
        n_out_pos        = r_out_pos;
        n_out_full       = r_out_full;
        n_out_last       = r_out_last;

        // register writes; the user must write only while idle, the block does not enforce it
        if (cfg_fire) begin
            case (i_cfg.reg_index)
                hct_pkg::CFG_IDX_PATTERN_LENGTH: begin
                    n_pattern_length = i_cfg.wr_data[hct_pkg::LENGTH_REG_W-1:0];
                    if (r_count == '0) begin
                        n_wend = PW'(eff_len(i_cfg.wr_data[hct_pkg::LENGTH_REG_W-1:0])
                                      - LEN_W'(1));
                    end
                end
                hct_pkg::CFG_IDX_PATTERN_LOW: begin
                    n_pattern_low = i_cfg.wr_data;
                end
                hct_pkg::CFG_IDX_PATTERN_HIGH: begin
                    n_pattern_high = i_cfg.wr_data;
                end
                default: begin
                end
            endcase
        end

        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            hct_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (stored) begin
                        n_count   = r_count + PW'(1);
                        n_wr_slot = slot_next(r_wr_slot);
                        if ((r_count == r_wend) && (r_count < PW'(len_m1))) begin
                            // length grew past the text seen so far
                            n_wend = PW'(len_m1);
                        end
                    end
                    if (start_cmp) begin
                        n_pos   = r_count;
                        n_slot  = r_wr_slot;
                        n_idx   = len_m1;
                        n_first = i_text.text_byte;
                        n_eot   = i_text.end_of_text;
                    end else if (i_text.end_of_text) begin
                        n_count   = '0;
                        n_wr_slot = '0;
                        n_wend    = PW'(len_m1);
                    end
                end
            end
            hct_pkg::ST_CMP: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = hct_pkg::COMPARED_POS_W'(r_pos + PW'(1));
                    n_out_full  = res_full;
                    n_out_last  = res_last;
                    if (res_last) begin
                        n_shift = len;
                        // full match skips the scan and keeps the length
                        n_scan  = res_full ? len_m1 : '0;
                        // first compare failed: window byte, else pattern's last byte
                        n_sym   = (r_idx == len_m1) ? text_cur : pat_byte(pv, len_m1);
                    end else begin
                        n_idx  = IDX_W'(r_idx - IDX_W'(1));
                        n_pos  = r_pos - PW'(1);
                        n_slot = slot_prev(r_slot);
                    end
                end
            end
            hct_pkg::ST_SHIFT: begin
                if (!scan_done) begin
                    if (shift_hit) begin
                        n_shift = LEN_W'(len - LEN_W'(1) - LEN_W'(r_scan));
                    end
                    n_scan = IDX_W'(r_scan + IDX_W'(1));
                end else begin
                    n_wend = wend_sat;
                    if (r_eot) begin
                        n_count   = '0;
                        n_wr_slot = '0;
                        n_wend    = PW'(len_m1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= hct_pkg::ST_IDLE;
            r_pattern_length <= hct_pkg::LENGTH_REG_W'(1);
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_count          <= '0;
            r_wend           <= '0;
            r_wr_slot        <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_pattern_length <= n_pattern_length;
            r_pattern_low    <= n_pattern_low;
            r_pattern_high   <= n_pattern_high;
            r_count          <= n_count;
            r_wend           <= n_wend;
            r_wr_slot        <= n_wr_slot;
            r_out_valid      <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_slot     <= n_slot;
        r_idx      <= n_idx;
        r_first    <= n_first;
        r_eot      <= n_eot;
        r_sym      <= n_sym;
        r_scan     <= n_scan;
        r_shift    <= n_shift;
        r_out_pos  <= n_out_pos;
        r_out_full <= n_out_full;
        r_out_last <= n_out_last;
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.compared_position = r_out_pos;
    assign o_result.window_matched    = r_out_full;
    assign o_result.last_of_run       = r_out_last;

    // a completed window always starts a compare run
    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && start_cmp) |=> (r_state == hct_pkg::ST_CMP))
        else $error("completed window did not start a compare run");

    // a full match closes its run
    a_match_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.window_matched) |-> o_result.last_of_run)
        else $error("window match reported on a result that is not last");

    // the compare index stays inside the pattern
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hct_pkg::ST_CMP) |-> (r_idx <= len_m1))
        else $error("compare index past pattern length");

    // the shift scan stays inside the pattern
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hct_pkg::ST_SHIFT) |-> (r_scan <= len_m1))
        else $error("shift scan index past pattern length");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the horspool comparison tracer
// streams text bytes against programmed patterns and checks every compare
// transaction against an in-bench model of the window search and its shifts
// ----------------------------------------------------------------------------
module tb_top;

    // bench constants
    localparam int MAX_PAT       = hct_pkg::MAX_PATTERN_DEF;
    localparam longint unsigned POS_SAT = (64'd1 << hct_pkg::POSITION_WIDTH_DEF) - 64'd1;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES = 40;    // covers the worst window, plus margin
    localparam logic [7:0] ALPHA_BASE = 8'h61;  // small alphabet 'a'..'c'
    // index 3 decodes to no register
    localparam logic [hct_pkg::CFG_INDEX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    // one compare transaction as seen on o_result
    typedef struct packed {
        logic [hct_pkg::COMPARED_POS_W-1:0] position;
        logic                               matched;
        logic                               last;
    } t_cmp_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hct_text_if   text_ch ();
    hct_result_if res_ch ();
    hct_cfg_if    cfg_ch ();

    horspool_comparison_tracer_top #(
        .MAX_PATTERN    (hct_pkg::MAX_PATTERN_DEF),
        .POSITION_WIDTH (hct_pkg::POSITION_WIDTH_DEF)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // search model state: programmed registers, byte ring, position counters
    // ------------------------------------------------------------------------
    logic [hct_pkg::LENGTH_REG_W-1:0] model_len_reg = 5'd1;
    logic [63:0]             model_pat_lo = '0;
    logic [63:0]             model_pat_hi = '0;
    logic [7:0]              text_ring [MAX_PAT];
    longint unsigned         taken_count = 0;
    longint unsigned         window_last = 0;   // 0-based end of current window

    // compares still owed by the block, oldest first
    t_cmp_result expected_cmps [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int bytes_taken   = 0;
    int cmps_checked  = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;

    // out-of-range lengths fold into 1..MAX_PAT
    function automatic int eff_len();
        int n;
        n = model_len_reg;
        if (n == 0) n = 1;
        if (n > MAX_PAT) n = MAX_PAT;
        return n;
    endfunction

    function automatic logic [7:0] pat_at(input int i);
        if (i < 8) return model_pat_lo[8*i +: 8];
        if (i < 16) return model_pat_hi[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    // last-occurrence shift, looking only at pattern bytes 0..len-2
    function automatic int bad_char_shift(input logic [7:0] sym, input int len);
        int s;
        int i;
        s = len;
        for (i = 0; i + 1 < len; i++)
            if (pat_at(i) == sym) s = len - 1 - i;
        return s;
    endfunction

    function automatic longint unsigned sat_sum(input longint unsigned a, input int b);
        longint unsigned r;
        r = a + longint'(b);
        if (r > POS_SAT || r < a) r = POS_SAT;
        return r;
    endfunction

    task automatic apply_reg(input logic [hct_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        case (idx)
            hct_pkg::CFG_IDX_PATTERN_LENGTH: begin
                model_len_reg = data[hct_pkg::LENGTH_REG_W-1:0];
                // before the first byte the window end follows the new length
                if (taken_count == 0) window_last = eff_len() - 1;
            end
            hct_pkg::CFG_IDX_PATTERN_LOW:  model_pat_lo = data;
            hct_pkg::CFG_IDX_PATTERN_HIGH: model_pat_hi = data;
            default: ;
        endcase
    endtask

    // one accepted text byte: store it, and if it closes the window, walk the
    // window right to left and queue one compare per byte until a mismatch
    task automatic predict_text(input logic [7:0] b, input logic eot);
        int              len;
        int              i;
        int              shift;
        longint unsigned p;
        longint unsigned start;
        longint unsigned pos;
        logic [7:0]      seen;
        bit              some_match;
        bit              done;
        t_cmp_result     r;
        len = eff_len();
        if (taken_count < POS_SAT) begin
            p = taken_count;
            text_ring[p % MAX_PAT] = b;
            taken_count = p + 1;
            if (p == window_last) begin
                if (p + 1 < len) begin
                    // length grew mid-text: window would start before byte 0
                    window_last = len - 1;
                end else begin
                    start = p + 1 - len;
                    some_match = 1'b0;
                    done = 1'b0;
                    for (i = len - 1; i >= 0 && !done; i--) begin
                        pos = start + i;
                        seen = text_ring[pos % MAX_PAT];
                        r.position = hct_pkg::COMPARED_POS_W'(pos + 1);
                        r.matched = 1'b0;
                        r.last = 1'b0;
                        shift = 0;
                        if (seen == pat_at(i)) begin
                            some_match = 1'b1;
                            if (i == 0) begin
                                r.matched = 1'b1;
                                r.last = 1'b1;
                                shift = len;
                            end
                        end else if (!some_match) begin
                            r.last = 1'b1;
                            shift = bad_char_shift(seen, len);
                        end else begin
                            r.last = 1'b1;
                            shift = bad_char_shift(pat_at(len - 1), len);
                        end
                        expected_cmps.push_back(r);
                        if (r.last) begin
                            window_last = sat_sum(window_last, shift);
                            done = 1'b1;
                        end
                    end
                end
            end
        end
        if (eot) begin
            taken_count = 0;
            window_last = len - 1;
        end
    endtask

    task automatic check_result();
        t_cmp_result want;
        cmps_checked++;
        if (expected_cmps.size() == 0) begin
            $error("unexpected compare transaction at position %0d",
                   res_ch.compared_position);
            fail_count++;
        end else begin
            want = expected_cmps.pop_front();
            if (res_ch.compared_position !== want.position) begin
                $error("compared_position: expected %0d, actual %0d",
                       want.position, res_ch.compared_position);
                fail_count++;
            end
            if (res_ch.window_matched !== want.matched) begin
                $error("window_matched: expected %0d, actual %0d",
                       want.matched, res_ch.window_matched);
                fail_count++;
            end
            if (res_ch.last_of_run !== want.last) begin
                $error("last_of_run: expected %0d, actual %0d",
                       want.last, res_ch.last_of_run);
                fail_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // monitor: all handshakes sampled at the rising edge in one process, so
    // register writes, predictions and checks always land in the same order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_reg(cfg_ch.reg_index, cfg_ch.wr_data);
                reg_writes++;
            end
            if (text_ch.valid && text_ch.ready) begin
                predict_text(text_ch.text_byte, text_ch.end_of_text);
                bytes_taken++;
            end
            if (res_ch.valid && res_ch.ready)
                check_result();
            // watchdog: a hung handshake ends the run
            if ((cfg_ch.valid && cfg_ch.ready) || (text_ch.valid && text_ch.ready) ||
                (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // drivers, all called and returning at a falling edge
    // ------------------------------------------------------------------------

    // one text transaction; valid is left high so back-to-back bytes never
    // drop it, and is lowered only when an idle gap is drawn
    task automatic send_text(input logic [7:0] b, input logic eot);
        if ($urandom_range(99) < send_idle_pct) begin
            text_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= eot;
        do @(posedge i_clk); while (!text_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [hct_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic program_pattern(input logic [4:0] len_val, input logic [63:0] lo,
                                   input logic [63:0] hi, input bit poke_unused);
        write_reg(hct_pkg::CFG_IDX_PATTERN_LOW, lo);
        write_reg(hct_pkg::CFG_IDX_PATTERN_HIGH, hi);
        if (poke_unused) write_reg(CFG_IDX_UNUSED, {$urandom, $urandom});
        write_reg(hct_pkg::CFG_IDX_PATTERN_LENGTH, 64'(len_val));
        cfg_ch.valid <= 1'b0;
    endtask

    // stop sending, let every owed compare drain, then let the shift scan of
    // the last window finish before the block may be reprogrammed
    task automatic wait_block_idle();
        text_ch.valid <= 1'b0;
        while (expected_cmps.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------

    // length 0 folds to 1; extreme bytes; then a 4-byte pattern hit by a
    // bad-character miss, a full match and a late mismatch
    task automatic test_short_patterns();
        program_pattern(5'd0, 64'h0, 64'h0, 1'b1);
        send_text(8'h00, 1'b0);   // single-byte match
        send_text(8'hFF, 1'b1);   // single-byte miss, end of text
        wait_block_idle();
        program_pattern(5'd4, 64'h4443_4241, 64'h0, 1'b0);   // "ABCD"
        send_text(8'h5A, 1'b0);   // "ZABC": rightmost miss on 'C'
        send_text(8'h41, 1'b0);
        send_text(8'h42, 1'b0);
        send_text(8'h43, 1'b0);
        send_text(8'h44, 1'b0);   // "ABCD": full match
        send_text(8'h58, 1'b0);
        send_text(8'h42, 1'b0);
        send_text(8'h43, 1'b0);
        send_text(8'h44, 1'b1);   // "XBCD": mismatch on the leftmost byte
        wait_block_idle();
    endtask

    // the length grows mid-text so the next window would reach before byte 0
    task automatic test_window_before_text_start();
        program_pattern(5'd1, 64'h41, 64'h0, 1'b0);
        send_text(8'h41, 1'b0);
        wait_block_idle();
        program_pattern(5'd3, 64'h41_4241, 64'h0, 1'b0);   // "ABA"
        send_text(8'h42, 1'b0);   // window due too early: no compare
        send_text(8'h41, 1'b1);   // "ABA" matches in full
        wait_block_idle();
    endtask

    // length above the maximum folds to 16; uses both pattern words
    task automatic test_full_length_pattern();
        int i;
        program_pattern(5'd20, '1, '1, 1'b0);
        for (i = 0; i < MAX_PAT; i++) send_text(8'hFF, i == MAX_PAT - 1);
        wait_block_idle();
    endtask

    // ------------------------------------------------------------------------
    // random texts: mostly pattern copies and a three-letter alphabet so
    // partial matches and both shift rules get exercised
    // ------------------------------------------------------------------------
    task automatic random_texts(input int quota);
        logic [7:0]  pat_bytes [MAX_PAT];
        logic [7:0]  text_q [$];
        logic [63:0] lo;
        logic [63:0] hi;
        int          len_val;
        int          elen;
        int          pick;
        int          sent;
        int          mut;
        int          target;
        int          i;
        int          j;
        bit          full_range;
        bit          with_eot;
        sent = 0;
        while (sent < quota) begin
            wait_block_idle();
            pick = $urandom_range(99);
            if (pick < 8)
                len_val = ($urandom_range(1) != 0) ? 0 : $urandom_range(17, 31);
            else if (pick < 20)
                len_val = MAX_PAT;
            else
                len_val = $urandom_range(1, 8);
            elen = (len_val == 0) ? 1 : ((len_val > MAX_PAT) ? MAX_PAT : len_val);
            full_range = ($urandom_range(3) == 0);
            for (i = 0; i < MAX_PAT; i++) begin
                pat_bytes[i] = full_range ? 8'($urandom_range(255))
                                          : ALPHA_BASE + 8'($urandom_range(2));
                if (i < 8) lo[8*i +: 8] = pat_bytes[i];
                else hi[8*(i-8) +: 8] = pat_bytes[i];
            end
            program_pattern(5'(len_val), lo, hi, $urandom_range(9) == 0);
            text_q.delete();
            target = $urandom_range(6, 40);
            while (text_q.size() < target) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    // pattern copy, sometimes with one corrupted byte
                    mut = ($urandom_range(9) < 3) ? $urandom_range(elen - 1) : -1;
                    for (j = 0; j < elen; j++)
                        text_q.push_back((j == mut) ? 8'($urandom_range(255)) : pat_bytes[j]);
                end else if (pick < 85) begin
                    text_q.push_back(ALPHA_BASE + 8'($urandom_range(2)));
                end else begin
                    text_q.push_back(8'($urandom_range(255)));
                end
            end
            // some texts run on, so the next setting lands mid-text
            with_eot = ($urandom_range(4) != 0);
            for (j = 0; j < text_q.size(); j++)
                send_text(text_q[j], with_eot && (j == text_q.size() - 1));
            sent += text_q.size();
        end
        wait_block_idle();
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct = 31;
        recv_idle_pct = 45;
        random_texts(70);
    endtask

    task automatic test_random_receiver_idle();
        send_idle_pct = 45;
        recv_idle_pct = 31;
        random_texts(70);
    endtask

    task automatic test_random_no_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_texts(70);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= '0;
        text_ch.end_of_text <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.reg_index    <= '0;
        cfg_ch.wr_data      <= '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_patterns();
        test_window_before_text_start();
        test_full_length_pattern();
        test_random_sender_idle();
        test_random_receiver_idle();
        test_random_no_idle();

        $display("run: %0d text bytes, %0d compares checked, %0d register writes",
                 bytes_taken, cmps_checked, reg_writes);
        $display("run: folded lengths, early windows and three idle mixes exercised");
        if (fail_count == 0 && expected_cmps.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### horspool_comparison_tracer_top.f
design/hct_pkg.sv
design/hct_text_if.sv
design/hct_result_if.sv
design/hct_cfg_if.sv
design/hct_ram.sv
design/horspool_comparison_tracer_top.sv
verif/tb_top.sv
